FILE: hw/rtl/simb_pkg.sv
// Shared declarations for the sector interleave map builder.
// Holds the table size constants and the control bundle that the sequencer
// sends to the slot table. No dependencies.
package simb_pkg;

    localparam int MAX_SECTORS = 64;
    localparam int SLOT_W      = $clog2(MAX_SECTORS);
    localparam int COUNT_W     = $clog2(MAX_SECTORS + 1);

    // Requests from the sequencer to the slot table.
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [SLOT_W-1:0] wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic [SLOT_W-1:0] probe_addr;
    } simb_table_ctrl_t;

endpackage

FILE: hw/rtl/simb_table.sv
// Slot table of the sector interleave map builder: the logical sector held
// in each physical slot (synchronous RAM) and the taken mark of each slot.
// Depends on simb_pkg.
module simb_table
    import simb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  simb_table_ctrl_t      ctrl,
    output logic                  probe_taken,
    output logic [SLOT_W-1:0]     rd_data
);

    logic [SLOT_W-1:0]      sector_ram_reg [MAX_SECTORS];
    logic [SLOT_W-1:0]      rd_data_reg;
    logic [MAX_SECTORS-1:0] taken_reg;
    logic [MAX_SECTORS-1:0] taken_next;

    // A clear leaves only slot 0 marked, since slot 0 always holds sector 0.
    always_comb
    begin
        taken_next = taken_reg;
        if (ctrl.clear)
        begin
            taken_next    = '0;
            taken_next[0] = 1'b1;
        end
        else if (ctrl.wr_en)
        begin
            taken_next[ctrl.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else
        begin
            taken_reg <= taken_next;
        end
    end

    // Single write port, single registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            sector_ram_reg[0] <= '0;
        end
        else if (ctrl.wr_en)
        begin
            sector_ram_reg[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= sector_ram_reg[ctrl.rd_addr];
        end
    end

    assign probe_taken = taken_reg[ctrl.probe_addr];
    assign rd_data     = rd_data_reg;

endmodule

FILE: hw/rtl/sector_interleave_map_builder.sv
// Sector interleave map builder: one request beat yields one entry beat per sector
// (sector_count held at 64, no beats for a zero count). The interleave is first reduced
// by repeated subtraction, then each sector takes an advance step and probes slot by
// slot until it finds a free one, then each entry beat takes a read and a load.
// Only one request at a time is taken: req_stall is high while the sequencer is not idle.
// Reset (rst_n, asynchronous) returns the sequencer to idle and drops the entry beat.
module sector_interleave_map_builder
    import simb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Request channel.
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [5:0]         interleave,
    input  logic [6:0]         sector_count,
    // Entry channel.
    output logic               entry_valid,
    input  logic               entry_stall,
    output logic [5:0]         slot,
    output logic [5:0]         logical_sector,
    output logic               last_entry
);

    // The sequencer walks through the phases of one build. The interleave is
    // first reduced modulo the sector count by repeated subtraction, so that
    // each later advance needs at most one subtraction. Each logical sector
    // then advances the position and probes forward, one slot per cycle,
    // until it finds a free slot. Finally the table is read out in slot order.
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_REDUCE  = 6'b000010,
        ST_ADVANCE = 6'b000100,
        ST_PROBE   = 6'b001000,
        ST_READ    = 6'b010000,
        ST_LOAD    = 6'b100000
    } simb_state_t;

    simb_state_t        state_reg,    state_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [SLOT_W-1:0]  step_reg,     step_next;
    logic [SLOT_W-1:0]  pos_reg,      pos_next;
    logic [COUNT_W-1:0] sector_reg,   sector_next;
    logic [SLOT_W-1:0]  emit_reg,     emit_next;
    logic               ovalid_reg,   ovalid_next;
    logic [SLOT_W-1:0]  oslot_reg,    oslot_next;
    logic [SLOT_W-1:0]  osector_reg,  osector_next;
    logic               olast_reg,    olast_next;

    simb_table_ctrl_t   table_ctrl;
    logic               probe_taken;
    logic [SLOT_W-1:0]  rd_data;

    logic               req_accept;
    logic [COUNT_W-1:0] count_sat;
    logic [COUNT_W-1:0] adv_sum;
    logic [COUNT_W-1:0] pos_inc;
    logic               out_free;
    logic               emit_last;

    simb_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (table_ctrl),
        .probe_taken (probe_taken),
        .rd_data     (rd_data)
    );

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;

    // Counts above the table size are held at the table size.
    assign count_sat = (sector_count > COUNT_W'(MAX_SECTORS)) ?
                       COUNT_W'(MAX_SECTORS) : sector_count;

    assign adv_sum   = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_inc   = {1'b0, pos_reg} + COUNT_W'(1);
    assign out_free  = !ovalid_reg || !entry_stall;
    assign emit_last = (({1'b0, emit_reg} + COUNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        pos_next     = pos_reg;
        sector_next  = sector_reg;
        emit_next    = emit_reg;
        ovalid_next  = ovalid_reg;
        oslot_next   = oslot_reg;
        osector_next = osector_reg;
        olast_next   = olast_reg;

        table_ctrl            = '0;
        table_ctrl.wr_addr    = pos_reg;
        table_ctrl.wr_data    = sector_reg[SLOT_W-1:0];
        table_ctrl.rd_addr    = emit_reg;
        table_ctrl.probe_addr = pos_reg;

        // The entry beat leaves as soon as it is taken.
        if (ovalid_reg && !entry_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    table_ctrl.clear = 1'b1;
                    count_next  = count_sat;
                    step_next   = interleave;
                    pos_next    = '0;
                    sector_next = COUNT_W'(1);
                    emit_next   = '0;
                    if (count_sat != '0)
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if ({1'b0, step_reg} >= count_reg)
                begin
                    step_next = SLOT_W'({1'b0, step_reg} - count_reg);
                end
                else if (sector_reg == count_reg)
                begin
                    // A single sector: only slot 0 is filled.
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE:
            begin
                // Both terms are below the count, so one subtraction suffices.
                if (adv_sum >= count_reg)
                begin
                    pos_next = SLOT_W'(adv_sum - count_reg);
                end
                else
                begin
                    pos_next = adv_sum[SLOT_W-1:0];
                end
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (pos_reg == '0 || probe_taken)
                begin
                    // Slot 0 is always taken, so a wrap resumes at slot 1.
                    if (pos_inc >= count_reg)
                    begin
                        pos_next = SLOT_W'(1);
                    end
                    else
                    begin
                        pos_next = pos_inc[SLOT_W-1:0];
                    end
                end
                else
                begin
                    table_ctrl.wr_en = 1'b1;
                    if ((sector_reg + COUNT_W'(1)) == count_reg)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        sector_next = sector_reg + COUNT_W'(1);
                        state_next  = ST_ADVANCE;
                    end
                end
            end
            ST_READ:
            begin
                table_ctrl.rd_en = 1'b1;
                state_next       = ST_LOAD;
            end
            ST_LOAD:
            begin
                // The read data holds until the next read, so waiting here is safe.
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    oslot_next   = emit_reg;
                    osector_next = rd_data;
                    olast_next   = emit_last;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next  = emit_reg + SLOT_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        step_reg    <= step_next;
        pos_reg     <= pos_next;
        sector_reg  <= sector_next;
        emit_reg    <= emit_next;
        oslot_reg   <= oslot_next;
        osector_reg <= osector_next;
        olast_reg   <= olast_next;
    end

    assign entry_valid    = ovalid_reg;
    assign slot           = oslot_reg;
    assign logical_sector = osector_reg;
    assign last_entry     = olast_reg;

endmodule
